### rtl/core/sds_pkg.sv
// Shared types, constants and constant functions of the scalar diffraction sum core.
// No dependencies; sds_queue, sds_front, sds_back and the top level import it.
package sds_pkg;

    localparam int POS_W = 48;
    localparam int AMP_W = 32;
    localparam int ACC_W = 64;
    localparam int CNT_W = 13;
    localparam int SLOT_W = 12;

    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] GAIN_Q30 = 64'h0000_0000_26DD_3B6A;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

    localparam logic [63:0] RST_PHASE_PER_UNIT = 64'd134137305283349675;
    localparam logic RST_REVERSE_DIRECTION = 1'b1;
    localparam logic [CNT_W-1:0] RST_SOURCE_COUNT = '0;

    typedef enum logic [1:0] {
        CFG_PHASE_PER_UNIT    = 2'd0,
        CFG_REVERSE_DIRECTION = 2'd1,
        CFG_SOURCE_COUNT      = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic [63:0]       phase_per_unit;
        logic              reverse_direction;
        logic [CNT_W-1:0]  source_count;
    } t_cfg;

    typedef struct packed {
        t_pos                    pos;
        logic signed [AMP_W-1:0] re;
        logic signed [AMP_W-1:0] im;
    } t_src;

    localparam int SRC_W = $bits(t_src);

    // Shift-subtract division, evaluated on constants only.
    function automatic logic [63:0] const_udiv(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Arctangent of 2^-i in Q60 from the alternating series.
    function automatic logic [63:0] atan_q60(int i);
        logic [63:0] acc;
        logic [63:0] term;
        acc = '0;
        term = '0;
        if (i == 0) begin
            return PI_Q60 >> 2;
        end
        for (int k = 1; k <= 61; k += 2) begin
            if (i * k <= 62) begin
                term = const_udiv(64'd1 << (62 - i * k), 64'(k));
                if (((k >> 1) & 1) != 0) acc = acc - term;
                else acc = acc + term;
            end
        end
        return acc >> 2;
    endfunction

endpackage

### rtl/core/sds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/sds_mul.sv
// 64x64 unsigned multiplier built from one 32x32 partial product per cycle.
// Depends on nothing; used by the back end of the core.
module sds_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [63:0]  r_pp;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;
    logic [31:0]  opa;
    logic [31:0]  opb;
    logic [1:0]   sh;

    always_comb begin
        case (r_cnt)
            3'd0:    begin opa = r_a[31:0];  opb = r_b[31:0];  sh = 2'd0; end
            3'd1:    begin opa = r_a[31:0];  opb = r_b[63:32]; sh = 2'd1; end
            3'd2:    begin opa = r_a[63:32]; opb = r_b[31:0];  sh = 2'd1; end
            default: begin opa = r_a[63:32]; opb = r_b[63:32]; sh = 2'd2; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pp <= 64'(opa) * 64'(opb);
                    r_sh <= sh;
                end
                if (r_cnt != 3'd0) begin
                    r_acc <= r_acc + ({64'd0, r_pp} << {r_sh, 5'd0});
                end
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### rtl/core/sds_queue.sv
// Two-entry queue of query positions between the front and back ends.
// Depends on sds_pkg for the position type.
module sds_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sds_pkg::t_pos i_push_pos,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_full,
    output sds_pkg::t_pos o_pos
);
    import sds_pkg::*;

    t_pos       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_push_pos;
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_pos   = r_mem[r_rp];
endmodule

### rtl/core/sds_front.sv
// Front end: configuration registers, input handshake, source table writes
// and query issue. Depends on sds_pkg.
module sds_front #(
    parameter int MAX_SOURCES = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [sds_pkg::SLOT_W-1:0]     i_slot,
    input  logic signed [sds_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [sds_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [sds_pkg::POS_W-1:0] i_pos_z,
    input  logic signed [sds_pkg::AMP_W-1:0] i_amp_re,
    input  logic signed [sds_pkg::AMP_W-1:0] i_amp_im,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    output sds_pkg::t_cfg                  o_cfg,
    output logic                           o_we,
    output logic [(MAX_SOURCES > 1 ? $clog2(MAX_SOURCES) : 1)-1:0] o_waddr,
    output sds_pkg::t_src                  o_wdata,
    output logic                           o_push,
    output sds_pkg::t_pos                  o_push_pos,
    input  logic                           i_q_full,
    input  logic                           i_q_empty,
    input  logic                           i_back_busy
);
    import sds_pkg::*;

    localparam int AW = MAX_SOURCES > 1 ? $clog2(MAX_SOURCES) : 1;

    t_cfg        r_cfg;
    logic        accept;
    logic        is_query;
    logic [16:0] slot_ext;

    assign is_query = (i_func == FUNC_QUERY);
    // Loads wait until every earlier query has finished reading the table.
    assign o_in_stall = is_query ? i_q_full : (!i_q_empty || i_back_busy);
    assign accept = i_in_valid && !o_in_stall;
    assign slot_ext = {5'd0, i_slot};

    assign o_we = accept && !is_query && (slot_ext < 17'(MAX_SOURCES));
    assign o_waddr = slot_ext[AW-1:0];
    assign o_wdata = '{pos: '{x: i_pos_x, y: i_pos_y, z: i_pos_z}, re: i_amp_re, im: i_amp_im};
    assign o_push = accept && is_query;
    assign o_push_pos = '{x: i_pos_x, y: i_pos_y, z: i_pos_z};

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_per_unit    <= RST_PHASE_PER_UNIT;
            r_cfg.reverse_direction <= RST_REVERSE_DIRECTION;
            r_cfg.source_count      <= RST_SOURCE_COUNT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PHASE_PER_UNIT:    r_cfg.phase_per_unit    <= i_cfg_data;
                CFG_REVERSE_DIRECTION: r_cfg.reverse_direction <= i_cfg_data[0];
                CFG_SOURCE_COUNT:      r_cfg.source_count      <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

### rtl/core/sds_back.sv
// Back end: walks the stored sources for one query through distance, phase,
// CORDIC, weight and complex accumulate. Depends on sds_pkg and sds_mul.
module sds_back #(
    parameter int MAX_SOURCES  = 4096,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sds_pkg::t_cfg        i_cfg,
    input  logic                 i_q_empty,
    input  sds_pkg::t_pos        i_q_pos,
    output logic                 o_pop,
    output logic                 o_busy,
    output logic                 o_re,
    output logic [(MAX_SOURCES > 1 ? $clog2(MAX_SOURCES) : 1)-1:0] o_raddr,
    input  sds_pkg::t_src        i_rdata,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [63:0]   o_field_re,
    output logic signed [63:0]   o_field_im
);
    import sds_pkg::*;

    localparam int AW = MAX_SOURCES > 1 ? $clog2(MAX_SOURCES) : 1;
    localparam int CW = $clog2(MAX_SOURCES + 1);
    localparam int SW = $clog2(CORDIC_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_LOAD, ST_SQUARE, ST_ROOT, ST_PHASE, ST_ANGLE,
        ST_CORDIC, ST_DIVIDE, ST_WROOT, ST_PROD, ST_ACCUM, ST_DONE
    } t_state;

    function automatic logic [63:0] mag64(logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // Q30 product on magnitudes, truncated, clamped, sign restored.
    function automatic logic [63:0] fin30(logic [127:0] p, logic neg);
        logic [63:0] m;
        m = p[93:30];
        if ((|p[127:94]) || m[63]) m = INT64_MAX;
        return neg ? (~m + 64'd1) : m;
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? INT64_MIN : INT64_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] sat_of_sign(logic [63:0] v);
        if (v[63]) return INT64_MIN;
        return (|v) ? INT64_MAX : 64'd0;
    endfunction

    logic [63:0] atan_tab [CORDIC_STEPS];
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
        assign atan_tab[g] = atan_q60(g);
    end

    t_state              r_st;
    t_pos                r_pos;
    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_j;
    logic [48:0]         r_ux, r_uy, r_uz;
    logic [31:0]         r_re, r_im;
    logic [97:0]         r_s;
    logic                r_zero;
    logic [2:0]          r_k;
    logic                r_mwait;
    logic [101:0]        r_rad;
    logic [55:0]         r_rem;
    logic [50:0]         r_root;
    logic [6:0]          r_it;
    logic [49:0]         r_r;
    logic [1:0]          r_quad;
    logic [61:0]         r_f;
    logic signed [63:0]  r_x, r_y, r_z;
    logic [63:0]         r_cv, r_sv;
    logic [49:0]         r_dv_rem;
    logic [100:0]        r_q;
    logic [50:0]         r_w;
    logic [63:0]         r_tr, r_ti, r_m1, r_m2, r_m3, r_m4;
    logic [63:0]         r_acc_re, r_acc_im;
    logic                r_out_valid;
    logic [63:0]         r_field_re, r_field_im;

    // Multiplier interface
    logic         mul_start;
    logic [63:0]  mul_a, mul_b;
    logic         mul_done;
    logic [127:0] mul_prod;
    logic         mul_neg;
    logic         in_mul_state;

    sds_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    logic [63:0] re64, im64;
    logic [48:0] sq_sel;
    assign re64 = {{32{r_re[31]}}, r_re};
    assign im64 = {{32{r_im[31]}}, r_im};
    assign sq_sel = (r_k == 3'd0) ? r_ux : ((r_k == 3'd1) ? r_uy : r_uz);

    assign in_mul_state = (r_st == ST_SQUARE) || (r_st == ST_PHASE) ||
                          (r_st == ST_ANGLE) || (r_st == ST_PROD);
    assign mul_start = in_mul_state && !r_mwait;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_neg = 1'b0;
        case (r_st)
            ST_SQUARE: begin
                mul_a = {15'd0, sq_sel};
                mul_b = {15'd0, sq_sel};
            end
            ST_PHASE: begin
                mul_a = {14'd0, r_r};
                mul_b = i_cfg.phase_per_unit;
            end
            ST_ANGLE: begin
                mul_a = {2'd0, r_f};
                mul_b = PI_Q60;
            end
            ST_PROD: begin
                case (r_k)
                    3'd0: begin
                        mul_a = mag64(r_cv); mul_b = {13'd0, r_w}; mul_neg = r_cv[63];
                    end
                    3'd1: begin
                        mul_a = mag64(r_sv); mul_b = {13'd0, r_w}; mul_neg = r_sv[63];
                    end
                    3'd2: begin
                        mul_a = mag64(re64); mul_b = mag64(r_tr); mul_neg = re64[63] ^ r_tr[63];
                    end
                    3'd3: begin
                        mul_a = mag64(im64); mul_b = mag64(r_ti); mul_neg = im64[63] ^ r_ti[63];
                    end
                    3'd4: begin
                        mul_a = mag64(re64); mul_b = mag64(r_ti); mul_neg = re64[63] ^ r_ti[63];
                    end
                    default: begin
                        mul_a = mag64(im64); mul_b = mag64(r_tr); mul_neg = im64[63] ^ r_tr[63];
                    end
                endcase
            end
            default: ;
        endcase
    end

    // One digit of the square root per cycle
    logic [55:0] sq_rem2, sq_trial, n_rem;
    logic [50:0] n_root;
    logic        sq_ge;
    assign sq_rem2  = {r_rem[53:0], r_rad[101:100]};
    assign sq_trial = {3'd0, r_root, 2'b01};
    assign sq_ge    = (sq_rem2 >= sq_trial);
    assign n_rem    = sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
    assign n_root   = {r_root[49:0], sq_ge};

    // One quotient bit of 2^100 / r per cycle
    logic [50:0]  dv_rem2, dv_sub;
    logic         dv_ge;
    logic [100:0] n_q;
    assign dv_rem2 = {r_dv_rem, (r_it == 7'd0)};
    assign dv_ge   = (dv_rem2 >= {1'b0, r_r});
    assign dv_sub  = dv_ge ? (dv_rem2 - {1'b0, r_r}) : dv_rem2;
    assign n_q     = {r_q[99:0], dv_ge};

    // CORDIC step
    logic signed [63:0] xs, ys, n_x, n_y, n_z;
    logic [63:0]        at;
    assign xs = r_x >>> r_it;
    assign ys = r_y >>> r_it;
    assign at = atan_tab[r_it[SW-1:0]];
    always_comb begin
        if (!r_z[63]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - $signed(at);
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + $signed(at);
        end
    end

    logic [97:0]  n_s;
    logic [63:0]  res30;
    logic [48:0]  dx, dy, dz;
    logic [16:0]  cnt_ext, n_lim;
    assign n_s   = r_s + mul_prod[97:0];
    assign res30 = fin30(mul_prod, mul_neg);
    assign dx = {r_pos.x[47], r_pos.x} - {i_rdata.pos.x[47], i_rdata.pos.x};
    assign dy = {r_pos.y[47], r_pos.y} - {i_rdata.pos.y[47], i_rdata.pos.y};
    assign dz = {r_pos.z[47], r_pos.z} - {i_rdata.pos.z[47], i_rdata.pos.z};
    assign cnt_ext = {4'd0, i_cfg.source_count};
    assign n_lim = (cnt_ext > 17'(MAX_SOURCES)) ? 17'(MAX_SOURCES) : cnt_ext;

    assign o_pop   = (r_st == ST_IDLE) && !i_q_empty;
    assign o_busy  = (r_st != ST_IDLE);
    assign o_re    = (r_st == ST_READ) && (r_j != r_n);
    assign o_raddr = r_j[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_mwait     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_st != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (mul_start) begin
                r_mwait <= 1'b1;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_pos    <= i_q_pos;
                        r_n      <= CW'(n_lim);
                        r_j      <= '0;
                        r_acc_re <= '0;
                        r_acc_im <= '0;
                        r_st     <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_st <= (r_j == r_n) ? ST_DONE : ST_LOAD;
                end
                ST_LOAD: begin
                    r_ux <= dx[48] ? (~dx + 49'd1) : dx;
                    r_uy <= dy[48] ? (~dy + 49'd1) : dy;
                    r_uz <= dz[48] ? (~dz + 49'd1) : dz;
                    r_re <= i_rdata.re;
                    r_im <= i_rdata.im;
                    r_s  <= '0;
                    r_k  <= '0;
                    r_st <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    if (mul_done) begin
                        r_mwait <= 1'b0;
                        r_s     <= n_s;
                        r_k     <= r_k + 3'd1;
                        if (r_k == 3'd2) begin
                            // Coincident points take the saturated path
                            r_zero <= (n_s == '0);
                            r_rad  <= {4'd0, n_s};
                            r_rem  <= '0;
                            r_root <= '0;
                            r_it   <= '0;
                            r_st   <= (n_s == '0) ? ST_ACCUM : ST_ROOT;
                        end
                    end
                end
                ST_ROOT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_rad  <= {r_rad[99:0], 2'b00};
                    r_it   <= r_it + 7'd1;
                    if (r_it == 7'd50) begin
                        r_r  <= n_root[49:0];
                        r_st <= ST_PHASE;
                    end
                end
                ST_PHASE: begin
                    if (mul_done) begin
                        r_mwait <= 1'b0;
                        r_quad  <= mul_prod[63:62];
                        r_f     <= mul_prod[61:0];
                        r_st    <= ST_ANGLE;
                    end
                end
                ST_ANGLE: begin
                    if (mul_done) begin
                        r_mwait <= 1'b0;
                        r_z     <= $signed(mul_prod[126:63]);
                        r_x     <= $signed(GAIN_Q30);
                        r_y     <= '0;
                        r_it    <= '0;
                        r_st    <= ST_CORDIC;
                    end
                end
                ST_CORDIC: begin
                    r_x  <= n_x;
                    r_y  <= n_y;
                    r_z  <= n_z;
                    if (r_it == 7'(CORDIC_STEPS - 1)) begin
                        case (r_quad)
                            2'd0:    begin r_cv <= n_x;  r_sv <= n_y;  end
                            2'd1:    begin r_cv <= -n_y; r_sv <= n_x;  end
                            2'd2:    begin r_cv <= -n_x; r_sv <= -n_y; end
                            default: begin r_cv <= n_y;  r_sv <= -n_x; end
                        endcase
                        r_dv_rem <= '0;
                        r_q      <= '0;
                        r_it     <= '0;
                        r_st     <= ST_DIVIDE;
                    end else begin
                        r_it <= r_it + 7'd1;
                    end
                end
                ST_DIVIDE: begin
                    r_dv_rem <= dv_sub[49:0];
                    r_q      <= n_q;
                    if (r_it == 7'd100) begin
                        r_rad  <= {1'b0, n_q};
                        r_rem  <= '0;
                        r_root <= '0;
                        r_it   <= '0;
                        r_st   <= ST_WROOT;
                    end else begin
                        r_it <= r_it + 7'd1;
                    end
                end
                ST_WROOT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_rad  <= {r_rad[99:0], 2'b00};
                    r_it   <= r_it + 7'd1;
                    if (r_it == 7'd50) begin
                        r_w  <= n_root;
                        r_k  <= '0;
                        r_st <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    if (mul_done) begin
                        r_mwait <= 1'b0;
                        r_k     <= r_k + 3'd1;
                        case (r_k)
                            3'd0: r_tr <= res30;
                            3'd1: r_ti <= i_cfg.reverse_direction ? res30 : (~res30 + 64'd1);
                            3'd2: r_m1 <= res30;
                            3'd3: r_m2 <= res30;
                            3'd4: r_m3 <= res30;
                            default: begin
                                r_m4 <= res30;
                                r_st <= ST_ACCUM;
                            end
                        endcase
                    end
                end
                ST_ACCUM: begin
                    if (r_zero) begin
                        r_acc_re <= sat_add(r_acc_re, sat_of_sign(re64));
                        r_acc_im <= sat_add(r_acc_im, sat_of_sign(im64));
                    end else begin
                        r_acc_re <= sat_add(r_acc_re, r_m1 - r_m2);
                        r_acc_im <= sat_add(r_acc_im, r_m3 + r_m4);
                    end
                    r_j  <= r_j + CW'(1);
                    r_st <= ST_READ;
                end
                ST_DONE: begin
                    // Hold the sum until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_field_re  <= r_acc_re;
                        r_field_im  <= r_acc_im;
                        r_out_valid <= 1'b1;
                        r_st        <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_field_re  = $signed(r_field_re);
    assign o_field_im  = $signed(r_field_im);
endmodule

### rtl/core/scalar_diffraction_sum_core.sv
// Top level of the scalar diffraction sum core: front end, query queue,
// source table RAM and back end. Depends on sds_pkg and all sds_* modules.
//
// Input channel (i_in_valid / o_in_stall): a load item (i_func = 0) writes one
// source point into the table at i_slot; a query item (i_func = 1) asks for the
// summed field at i_pos_*. Output channel (o_out_valid / i_out_stall) returns one
// result per query. Configuration writes use i_cfg_valid / o_cfg_ready with
// i_cfg_index and i_cfg_data; o_cfg_ready is always high.
// Queries queue two deep; loads stall until every earlier query has finished.
// A query's run time is set, for each summed source, by the bit-serial square
// roots, the bit-serial weight divider, the CORDIC rotations and the shared
// 32x32 multiplier (11 products per source); a source at zero distance needs
// only its three squaring products.
// Reset is synchronous, returns the registers to their defaults and empties
// the queue and output; the source table is not cleared. While the receiver
// stalls, the finished result holds in the output register and the next query
// still runs up to its own result.
module scalar_diffraction_sum_core #(
    parameter int MAX_SOURCES  = 4096,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic [11:0]         i_slot,
    input  logic signed [47:0]  i_pos_x,
    input  logic signed [47:0]  i_pos_y,
    input  logic signed [47:0]  i_pos_z,
    input  logic signed [31:0]  i_amp_re,
    input  logic signed [31:0]  i_amp_im,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [63:0]  o_field_re,
    output logic signed [63:0]  o_field_im,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);
    import sds_pkg::*;

    localparam int AW = MAX_SOURCES > 1 ? $clog2(MAX_SOURCES) : 1;

    t_cfg          cfg;
    logic          we;
    logic [AW-1:0] waddr;
    t_src          wdata;
    logic          re;
    logic [AW-1:0] raddr;
    t_src          rdata;
    logic          push;
    t_pos          push_pos;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    t_pos          q_pos;
    logic          back_busy;

    sds_front #(.MAX_SOURCES(MAX_SOURCES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_slot      (i_slot),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_amp_re    (i_amp_re),
        .i_amp_im    (i_amp_im),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_push      (push),
        .o_push_pos  (push_pos),
        .i_q_full    (q_full),
        .i_q_empty   (q_empty),
        .i_back_busy (back_busy)
    );

    sds_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_pos (push_pos),
        .i_pop      (pop),
        .o_empty    (q_empty),
        .o_full     (q_full),
        .o_pos      (q_pos)
    );

    sds_ram #(.WIDTH(SRC_W), .DEPTH(MAX_SOURCES)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sds_back #(.MAX_SOURCES(MAX_SOURCES), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .i_q_pos     (q_pos),
        .o_pop       (pop),
        .o_busy      (back_busy),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_field_re  (o_field_re),
        .o_field_im  (o_field_im)
    );

    a_load_after_queries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we |-> (!back_busy && q_empty)))
        else $error("table write while a query is in flight");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && q_full |-> pop))
        else $error("query queue overflow");

    a_table_read_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (re |-> back_busy && !we))
        else $error("table read outside a query");

    a_reset_clears_output: assert property (@(posedge i_clk)
        (!i_rst_n |=> !o_out_valid))
        else $error("output valid after reset");
endmodule

### dv/scalar_diffraction_sum_core_test.sv
// Self-checking testbench for scalar_diffraction_sum_core: source loads, field queries
// and register writes, checked against a bit-exact field predictor. Depends on sds_pkg.
module scalar_diffraction_sum_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sds_pkg::*;

    localparam int TABLE_DEPTH = 4096;
    localparam int ROTATIONS   = 24;
    localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;
    localparam logic signed [31:0] AMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] AMP_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [63:0] re;
        logic signed [63:0] im;
    } t_field;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_func;
    logic [11:0]         i_slot;
    logic signed [47:0]  i_pos_x;
    logic signed [47:0]  i_pos_y;
    logic signed [47:0]  i_pos_z;
    logic signed [31:0]  i_amp_re;
    logic signed [31:0]  i_amp_im;
    logic                o_out_valid;
    logic                i_out_stall;
    logic signed [63:0]  o_field_re;
    logic signed [63:0]  o_field_im;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [63:0]         i_cfg_data;

    scalar_diffraction_sum_core dut (.*);

    // Mirror of the block's registers and source table
    logic [63:0]        wavenumber;
    logic               reverse;
    logic [12:0]        count;
    logic signed [47:0] src_x [TABLE_DEPTH];
    logic signed [47:0] src_y [TABLE_DEPTH];
    logic signed [47:0] src_z [TABLE_DEPTH];
    logic signed [31:0] src_re [TABLE_DEPTH];
    logic signed [31:0] src_im [TABLE_DEPTH];
    logic [63:0]        atan_tab [ROTATIONS];

    t_field pending_fields [$];
    int     errors;
    int     loads_sent;
    int     queries_sent;
    int     fields_seen;
    bit     gaps_on;
    bit     stalls_on;
    int     stall_run;
    bit     stall_now;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic void build_atan();
        logic [63:0] acc;
        logic [63:0] term;
        atan_tab[0] = PI_Q60 >> 2;
        for (int i = 1; i < ROTATIONS; i++) begin
            acc = '0;
            for (int k = 1; i * k <= 62; k += 2) begin
                term = (64'd1 << (62 - i * k)) / 64'(k);
                if (((k >> 1) & 1) != 0) acc = acc - term;
                else acc = acc + term;
            end
            atan_tab[i] = acc >> 2;
        end
    endfunction

    // Q30 product on magnitudes, truncated toward zero, saturating
    function automatic logic signed [63:0] q30_mul(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        ma = a[63] ? 64'd0 - a : a;
        mb = b[63] ? 64'd0 - b : b;
        p = ({64'd0, ma} * {64'd0, mb}) >> 30;
        if (p > {64'd0, INT64_MAX}) p = {64'd0, INT64_MAX};
        return (a[63] ^ b[63]) ? 64'd0 - p[63:0] : p[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({1'b0, INT64_MAX})) return INT64_MAX;
        if (s < $signed({1'b1, INT64_MIN})) return INT64_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sign_limit(logic signed [31:0] v);
        if (v > 0) return INT64_MAX;
        if (v < 0) return INT64_MIN;
        return '0;
    endfunction

    function automatic logic [63:0] dist_root(logic [127:0] s);
        logic [63:0] res;
        logic [63:0] c;
        res = '0;
        for (int b = 49; b >= 0; b--) begin
            c = res | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s) res = c;
        end
        return res;
    endfunction

    // Largest w with w*w*r <= 2^100
    function automatic logic [63:0] inv_sqrt_weight(logic [63:0] r);
        logic [63:0]  w;
        logic [63:0]  c;
        logic [255:0] t;
        w = '0;
        for (int b = 50; b >= 0; b--) begin
            c = w | (64'd1 << b);
            t = 256'(c) * 256'(c);
            t = t * 256'(r);
            if (t <= (256'd1 << 100)) w = c;
        end
        return w;
    endfunction

    function automatic void rotate_phase(logic [63:0] ph, output logic signed [63:0] cv,
                                         output logic signed [63:0] sv);
        logic [127:0]       p;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        p = {66'd0, ph[61:0]} * {64'd0, PI_Q60};
        z = p[126:63];
        x = GAIN_Q30;
        y = '0;
        for (int i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - atan_tab[i];
            end else begin
                x = x + ys; y = y - xs; z = z + atan_tab[i];
            end
        end
        case (ph[63:62])
            2'd0: begin cv = x;  sv = y;  end
            2'd1: begin cv = -y; sv = x;  end
            2'd2: begin cv = -x; sv = -y; end
            default: begin cv = y; sv = -x; end
        endcase
    endfunction

    function automatic t_field predict_field(logic signed [47:0] px, logic signed [47:0] py,
                                             logic signed [47:0] pz);
        t_field             f;
        int                 n;
        logic signed [63:0] d;
        logic [63:0]        ux;
        logic [63:0]        uy;
        logic [63:0]        uz;
        logic [127:0]       s;
        logic [63:0]        r;
        logic signed [63:0] cv;
        logic signed [63:0] sv;
        logic signed [63:0] w;
        logic signed [63:0] tr;
        logic signed [63:0] ti;
        logic signed [63:0] are;
        logic signed [63:0] aim;
        f.re = '0;
        f.im = '0;
        n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        for (int j = 0; j < n; j++) begin
            d = 64'(px) - 64'(src_x[j]); ux = d[63] ? -d : d;
            d = 64'(py) - 64'(src_y[j]); uy = d[63] ? -d : d;
            d = 64'(pz) - 64'(src_z[j]); uz = d[63] ? -d : d;
            s = {64'd0, ux} * {64'd0, ux} + {64'd0, uy} * {64'd0, uy}
                + {64'd0, uz} * {64'd0, uz};
            are = 64'(src_re[j]);
            aim = 64'(src_im[j]);
            if (s == 0) begin
                f.re = sat_sum(f.re, sign_limit(src_re[j]));
                f.im = sat_sum(f.im, sign_limit(src_im[j]));
            end else begin
                r = dist_root(s);
                rotate_phase(r * wavenumber, cv, sv);
                w = inv_sqrt_weight(r);
                tr = q30_mul(cv, w);
                ti = q30_mul(sv, w);
                if (!reverse) ti = -ti;
                f.re = sat_sum(f.re, q30_mul(are, tr) - q30_mul(aim, ti));
                f.im = sat_sum(f.im, q30_mul(are, ti) + q30_mul(aim, tr));
            end
        end
        return f;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Called right after a rising edge; returns right after one
    task automatic send_item(t_func func, logic [11:0] slot, logic signed [47:0] px,
                             logic signed [47:0] py, logic signed [47:0] pz,
                             logic signed [31:0] are, logic signed [31:0] aim);
        int gap;
        i_in_valid <= 1'b1;
        i_func <= func;
        i_slot <= slot;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        i_amp_re <= are;
        i_amp_im <= aim;
        do @(posedge i_clk); while (o_in_stall);
        if (func == FUNC_LOAD) begin
            src_x[slot] = px; src_y[slot] = py; src_z[slot] = pz;
            src_re[slot] = are; src_im[slot] = aim;
            loads_sent++;
        end else begin
            pending_fields = {pending_fields, predict_field(px, py, pz)};
            queries_sent++;
        end
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic query_at(logic signed [47:0] px, logic signed [47:0] py,
                            logic signed [47:0] pz);
        send_item(FUNC_QUERY, 12'($urandom()), px, py, pz, $urandom(), $urandom());
    endtask

    // Drain all results, then let a trailing load finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_fields.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PHASE_PER_UNIT:    wavenumber = value;
            CFG_REVERSE_DIRECTION: reverse = value[0];
            CFG_SOURCE_COUNT:      count = value[12:0];
            default: ;
        endcase
    endtask

    // Reset values: no sources summed, so the field is zero
    task automatic test_reset_state();
        query_at(rand48(), rand48(), rand48());
        query_at(POS_MAX, POS_MIN, '0);
        settle();
    endtask

    // Field extremes, zero distance of every amplitude sign, reset wavenumber
    task automatic test_extremes();
        send_item(FUNC_LOAD, 12'd0, POS_MAX, POS_MAX, POS_MAX, AMP_MAX, AMP_MIN);
        send_item(FUNC_LOAD, 12'd1, POS_MIN, POS_MIN, POS_MIN, AMP_MIN, AMP_MAX);
        send_item(FUNC_LOAD, 12'd2, '0, '0, '0, '0, AMP_MIN);
        send_item(FUNC_LOAD, 12'd3, 48'sd1, -48'sd1, 48'sd2, 32'sd1 << 30, -32'sd1);
        for (int s = 4; s < 8; s++)
            send_item(FUNC_LOAD, 12'(s), rand48(), rand48(), rand48(), $urandom(), $urandom());
        send_item(FUNC_LOAD, 12'hFFF, rand48(), rand48(), rand48(), $urandom(), $urandom());
        settle();
        write_reg(CFG_SOURCE_COUNT, 64'd4);
        query_at(POS_MAX, POS_MAX, POS_MAX);
        query_at(POS_MIN, POS_MIN, POS_MIN);
        query_at('0, '0, '0);
        query_at(48'sd1, -48'sd1, 48'sd2);
        query_at(48'sd1, -48'sd1, 48'sd3);
        query_at(POS_MIN, POS_MAX, '0);
        settle();
    endtask

    // Register extremes; the full and over-range counts are written but not queried
    task automatic test_registers();
        write_reg(CFG_SOURCE_COUNT, 64'd8191);
        write_reg(CFG_SOURCE_COUNT, 64'd4096);
        write_reg(CFG_SOURCE_COUNT, 64'd1);
        write_reg(CFG_PHASE_PER_UNIT, '0);
        write_reg(CFG_REVERSE_DIRECTION, 64'd0);
        query_at(48'sd5, 48'sd5, 48'sd5);
        settle();
        write_reg(CFG_PHASE_PER_UNIT, '1);
        write_reg(CFG_REVERSE_DIRECTION, '1);
        write_reg(CFG_SOURCE_COUNT, 64'd8);
        query_at(rand48(), rand48(), rand48());
        query_at(48'sd100, -48'sd7, 48'sd0);
        settle();
    endtask

    task automatic test_random(int rounds, int per_round);
        int                 kind;
        int                 ref_slot;
        logic [11:0]        slot;
        logic signed [47:0] px;
        logic signed [47:0] py;
        logic signed [47:0] pz;
        for (int p = 0; p < rounds; p++) begin
            gaps_on = (p % 3) != 2;
            stalls_on = (p % 4) != 3;
            write_reg(CFG_PHASE_PER_UNIT, {$urandom(), $urandom()});
            write_reg(CFG_REVERSE_DIRECTION, {$urandom(), $urandom()});
            write_reg(CFG_SOURCE_COUNT, 64'($urandom_range(1, 8)));
            for (int k = 0; k < per_round; k++) begin
                kind = $urandom_range(0, 99);
                if (kind < 35) begin
                    slot = ($urandom_range(0, 9) == 0) ? 12'($urandom()) :
                           12'($urandom_range(0, 7));
                    send_item(FUNC_LOAD, slot, rand48(), rand48(), rand48(),
                              $urandom(), $urandom());
                end else begin
                    ref_slot = $urandom_range(0, 7);
                    px = rand48(); py = rand48(); pz = rand48();
                    if (kind < 50) begin
                        px = src_x[ref_slot]; py = src_y[ref_slot]; pz = src_z[ref_slot];
                    end else if (kind < 70) begin
                        px = src_x[ref_slot] + 48'($signed($urandom_range(0, 2000)) - 1000);
                        py = src_y[ref_slot] + 48'($signed($urandom_range(0, 2000)) - 1000);
                        pz = src_z[ref_slot];
                    end
                    query_at(px, py, pz);
                end
            end
            settle();
        end
    endtask

    // Result checker and receiver stall pattern
    always @(posedge i_clk) begin
        t_field want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_run = 0;
            stall_now = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                fields_seen++;
                if (pending_fields.size() == 0) begin
                    report_mismatch("unexpected result", o_field_re, '0);
                end else begin
                    want = pending_fields.pop_front();
                    if (o_field_re !== want.re) report_mismatch("field_re", o_field_re, want.re);
                    if (o_field_im !== want.im) report_mismatch("field_im", o_field_im, want.im);
                end
            end
            if (stall_run == 0) begin
                stall_now = stalls_on && ($urandom_range(0, 2) == 0);
                stall_run = pick_gap() + 1;
            end
            stall_run--;
            i_out_stall <= stall_now;
        end
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        errors = 0;
        loads_sent = 0;
        queries_sent = 0;
        fields_seen = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        wavenumber = RST_PHASE_PER_UNIT;
        reverse = RST_REVERSE_DIRECTION;
        count = RST_SOURCE_COUNT;
        build_atan();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = FUNC_LOAD;
        i_slot = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_amp_re = '0;
        i_amp_im = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PHASE_PER_UNIT;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_extremes();
        test_registers();
        test_random(4, 30);

        $display("Ran %0d source loads and %0d field queries; %0d results checked",
                 loads_sent, queries_sent, fields_seen);
        $display("covering zero distance, coordinate and amplitude extremes, both directions");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/sds_pkg.sv
rtl/core/sds_ram.sv
rtl/core/sds_mul.sv
rtl/core/sds_queue.sv
rtl/core/sds_front.sv
rtl/core/sds_back.sv
rtl/core/scalar_diffraction_sum_core.sv
dv/scalar_diffraction_sum_core_test.sv
